/* rtl/core/mexp_pkg.sv */
package mexp_pkg;

    // Width of the operand fields and of the result field on the item channels.
    localparam int unsigned DATA_W = 64;

    // Operation codes for the shared double-and-add unit.
    localparam logic [1:0] OP_REDUCE = 2'd0;  // base mod modulus
    localparam logic [1:0] OP_MUL_R  = 2'd1;  // result * power mod modulus
    localparam logic [1:0] OP_MUL_P  = 2'd2;  // power * power mod modulus

    typedef struct packed {
        logic [DATA_W-1:0] base_value;
        logic [DATA_W-1:0] exponent_value;
        logic [DATA_W-1:0] modulus_value;
    } operands_t;

    typedef struct packed {
        logic [DATA_W-1:0] power_result;
        logic              zero_modulus_error;
    } answer_t;

    typedef struct packed {
        logic       load;
        logic       op_start;
        logic [1:0] op_sel;
        logic       step;
        logic       wb_power;
        logic       wb_result;
        logic       shift_expo;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic mod_zero;
        logic expo_zero;
        logic expo_bit0;
        logic expo_last;
        logic out_busy;
    } dp_sts_t;

endpackage

/* rtl/core/mexp_dp.sv */
module mexp_dp #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mexp_pkg::operands_t opnd,
    output logic                res_valid,
    input  logic                res_stall,
    output mexp_pkg::answer_t   res,
    input  mexp_pkg::dp_cmd_t   cmd,
    output mexp_pkg::dp_sts_t   sts
);

    localparam int unsigned DW = mexp_pkg::DATA_W;
    localparam int unsigned EW = WIDTH + 2;

    logic [WIDTH-1:0] base_reg;
    logic [WIDTH-1:0] expo_reg;
    logic [WIDTH-1:0] mod_reg;
    logic [WIDTH-1:0] power_reg;
    logic [WIDTH-1:0] result_reg;
    logic [WIDTH-1:0] acc_reg;
    logic [WIDTH-1:0] mplier_reg;
    logic [WIDTH-1:0] addend_reg;
    logic             mod_zero_reg;
    logic             expo_zero_reg;
    mexp_pkg::answer_t out_reg;
    logic             out_valid_reg;

    logic [WIDTH-1:0] base_in;
    logic [WIDTH-1:0] expo_in;
    logic [WIDTH-1:0] mod_in;
    logic [WIDTH-1:0] addend_next;
    logic [WIDTH-1:0] mplier_next;
    logic [WIDTH-1:0] acc_next;
    logic [EW-1:0]    sum_w;
    logic [EW-1:0]    mod1_w;
    logic [EW-1:0]    mod2_w;
    logic [EW-1:0]    red_w;
    mexp_pkg::answer_t out_next;

    assign base_in = opnd.base_value[WIDTH-1:0];
    assign expo_in = opnd.exponent_value[WIDTH-1:0];
    assign mod_in  = opnd.modulus_value[WIDTH-1:0];

    // One double-and-add step: 2*acc plus the addend when the scanned bit is set.
    // Both terms are below the modulus, so the sum stays below three moduli.
    always_comb
    begin
        sum_w  = {1'b0, acc_reg, 1'b0}
               + (mplier_reg[WIDTH-1] ? {2'b00, addend_reg} : {EW{1'b0}});
        mod1_w = {2'b00, mod_reg};
        mod2_w = {1'b0, mod_reg, 1'b0};
        if (sum_w >= mod2_w)
        begin
            red_w = sum_w - mod2_w;
        end
        else if (sum_w >= mod1_w)
        begin
            red_w = sum_w - mod1_w;
        end
        else
        begin
            red_w = sum_w;
        end
        acc_next = red_w[WIDTH-1:0];
    end

    always_comb
    begin
        case (cmd.op_sel)
            mexp_pkg::OP_REDUCE:
            begin
                addend_next = WIDTH'(1);
                mplier_next = base_reg;
            end
            mexp_pkg::OP_MUL_R:
            begin
                addend_next = result_reg;
                mplier_next = power_reg;
            end
            mexp_pkg::OP_MUL_P:
            begin
                addend_next = power_reg;
                mplier_next = power_reg;
            end
            default:
            begin
                addend_next = '0;
                mplier_next = '0;
            end
        endcase
    end

    always_comb
    begin
        out_next.zero_modulus_error = mod_zero_reg;
        if (mod_zero_reg)
        begin
            out_next.power_result = '0;
        end
        else if (expo_zero_reg)
        begin
            out_next.power_result = DW'(1);
        end
        else
        begin
            out_next.power_result = DW'(result_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_reg      <= base_in;
            expo_reg      <= expo_in;
            mod_reg       <= mod_in;
            mod_zero_reg  <= (mod_in == '0);
            expo_zero_reg <= (expo_in == '0);
            result_reg    <= (mod_in == WIDTH'(1)) ? '0 : WIDTH'(1);
        end
        else
        begin
            if (cmd.shift_expo)
            begin
                expo_reg <= expo_reg >> 1;
            end
            if (cmd.wb_result)
            begin
                result_reg <= acc_next;
            end
        end

        if (cmd.wb_power)
        begin
            power_reg <= acc_next;
        end

        if (cmd.op_start)
        begin
            acc_reg    <= '0;
            mplier_reg <= mplier_next;
            addend_reg <= addend_next;
        end
        else if (cmd.step)
        begin
            acc_reg    <= acc_next;
            mplier_reg <= mplier_reg << 1;
        end

        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign sts.mod_zero  = mod_zero_reg;
    assign sts.expo_zero = expo_zero_reg;
    assign sts.expo_bit0 = expo_reg[0];
    assign sts.expo_last = ((expo_reg >> 1) == '0);
    assign sts.out_busy  = out_valid_reg && res_stall;

endmodule

/* rtl/core/mexp_ctrl.sv */
module mexp_ctrl #(
    parameter int unsigned WIDTH = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output mexp_pkg::dp_cmd_t cmd,
    input  mexp_pkg::dp_sts_t sts
);

    localparam int unsigned CNT_W = $clog2(WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_CHECK   = 3'd1;
    localparam logic [2:0] S_REDUCE  = 3'd2;
    localparam logic [2:0] S_DECIDE  = 3'd3;
    localparam logic [2:0] S_MUL_R   = 3'd4;
    localparam logic [2:0] S_ADVANCE = 3'd5;
    localparam logic [2:0] S_MUL_P   = 3'd6;
    localparam logic [2:0] S_FINISH  = 3'd7;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cnt_last;

    assign cnt_last = (cnt_reg == CNT_LAST);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        cmd.step   = state_reg inside {S_REDUCE, S_MUL_R, S_MUL_P};

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.mod_zero || sts.expo_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op_start = 1'b1;
                    cmd.op_sel   = mexp_pkg::OP_REDUCE;
                    state_next   = S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (cnt_last)
                begin
                    cmd.wb_power = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (sts.expo_bit0)
                begin
                    cmd.op_start = 1'b1;
                    cmd.op_sel   = mexp_pkg::OP_MUL_R;
                    state_next   = S_MUL_R;
                end
                else
                begin
                    state_next = S_ADVANCE;
                end
            end
            S_MUL_R:
            begin
                if (cnt_last)
                begin
                    cmd.wb_result = 1'b1;
                    state_next    = S_ADVANCE;
                end
            end
            S_ADVANCE:
            begin
                cmd.shift_expo = 1'b1;
                if (sts.expo_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op_start = 1'b1;
                    cmd.op_sel   = mexp_pkg::OP_MUL_P;
                    state_next   = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                if (cnt_last)
                begin
                    cmd.wb_power = 1'b1;
                    state_next   = S_DECIDE;
                end
            end
            S_FINISH:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op_start)
        begin
            cnt_next = '0;
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> (state_reg == S_CHECK))
        else $error("accepted beat did not move the controller to the check state");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_busy)
        else $error("output register loaded while a stalled beat is held");

    a_wb_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wb_power || cmd.wb_result) |-> (cnt_last && cmd.step))
        else $error("write-back before the last bit step");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op_start |=> (cnt_reg == '0))
        else $error("bit counter not cleared at operation start");
`endif

endmodule

/* rtl/core/modular_exponentiation.sv */
// Sequence: an item with a zero modulus or zero exponent goes from acceptance through the
// check state to the finish state, where its answer is loaded. Otherwise the base is first
// reduced, then per exponent bit up to the top set bit a multiply for a set bit and a squaring
// below the top bit follow, and the answer is loaded. The finish state waits while the output
// holds a stalled answer. One item at a time: the next one is accepted once the answer is loaded.
// Reset (rst_n low) empties the block; nothing else is cleared.
module modular_exponentiation #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                opnd_valid,
    output logic                opnd_stall,
    input  mexp_pkg::operands_t opnd,
    output logic                res_valid,
    input  logic                res_stall,
    output mexp_pkg::answer_t   res
);

    // The controller sequences right-to-left square-and-multiply: it first reduces the
    // base modulo the modulus, then for each exponent bit up to the top set bit optionally
    // multiplies the running result by the current power and, below the top bit, squares the
    // power. Every modular product is formed by the datapath's shared double-and-add unit, one
    // bit per cycle, with the partial sum kept below the modulus by a two-way conditional subtract.
    //
    // The answer sits in an output register, so a beat may wait at the output while the
    // next operand beat is already accepted and under way.

    mexp_pkg::dp_cmd_t cmd;
    mexp_pkg::dp_sts_t sts;

    mexp_ctrl #(
        .WIDTH (WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (opnd_valid),
        .in_stall (opnd_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Operands are truncated to WIDTH bits at capture; the answer is zero-extended.
    mexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .opnd      (opnd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* tb/modexp_checker.sv */
`timescale 1ns / 100ps

module modexp_checker #(
    parameter int unsigned WIDTH = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                opnd_valid,
    input  logic                opnd_stall,
    input  mexp_pkg::operands_t opnd,
    input  logic                res_valid,
    input  logic                res_stall,
    input  mexp_pkg::answer_t   res,
    output int                  fail_count,
    output int                  pending_answers
);

    localparam int unsigned DW = mexp_pkg::DATA_W;

    // Only the low WIDTH bits of each operand reach the arithmetic.
    localparam logic [DW-1:0] OPERAND_MASK = {DW{1'b1}} >> (DW - WIDTH);

    mexp_pkg::answer_t expected_answers[$];

    function automatic logic [DW-1:0] mul_mod_wide(input logic [DW-1:0] a,
                                                   input logic [DW-1:0] b,
                                                   input logic [DW-1:0] m);
        logic [2*DW-1:0] prod;
        prod = {{DW{1'b0}}, a} * {{DW{1'b0}}, b};
        return DW'(prod % {{DW{1'b0}}, m});
    endfunction

    function automatic mexp_pkg::answer_t power_mod(input mexp_pkg::operands_t x);
        logic [DW-1:0] b;
        logic [DW-1:0] e;
        logic [DW-1:0] m;
        logic [DW-1:0] acc;
        logic [DW-1:0] sq;
        mexp_pkg::answer_t ans;
        b = x.base_value & OPERAND_MASK;
        e = x.exponent_value & OPERAND_MASK;
        m = x.modulus_value & OPERAND_MASK;
        ans.power_result = '0;
        ans.zero_modulus_error = 1'b0;
        if (m == '0)
        begin
            ans.zero_modulus_error = 1'b1;
            return ans;
        end
        // A zero exponent answers 1 without any reduction, even for a modulus of one.
        if (e == '0)
        begin
            ans.power_result = DW'(1);
            return ans;
        end
        acc = DW'(1) % m;
        sq = b % m;
        while (e != '0)
        begin
            if (e[0])
                acc = mul_mod_wide(acc, sq, m);
            sq = mul_mod_wide(sq, sq, m);
            e = e >> 1;
        end
        ans.power_result = acc;
        return ans;
    endfunction

    always @(posedge clk)
    begin
        mexp_pkg::answer_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            expected_answers.delete();
            fail_count <= 0;
            pending_answers <= 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("result beat with nothing expected: power_result %h, error flag %b",
                           res.power_result, res.zero_modulus_error);
                    errs++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (res.power_result !== want.power_result)
                    begin
                        $error("power_result: expected %h, actual %h",
                               want.power_result, res.power_result);
                        errs++;
                    end
                    if (res.zero_modulus_error !== want.zero_modulus_error)
                    begin
                        $error("zero_modulus_error: expected %b, actual %b",
                               want.zero_modulus_error, res.zero_modulus_error);
                        errs++;
                    end
                end
            end
            if (opnd_valid && !opnd_stall)
                expected_answers.push_back(power_mod(opnd));
            fail_count <= fail_count + errs;
            pending_answers <= expected_answers.size();
        end
    end

endmodule

/* tb/modular_exponentiation_tb.sv */
`timescale 1ns / 100ps

module modular_exponentiation_tb;

    localparam int unsigned DUT_WIDTH = 64;
    localparam int unsigned RANDOM_ITEMS = 100;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
    // Largest prime below 2**64; it keeps every intermediate product large.
    localparam logic [63:0] BIG_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;

    logic                clk;
    logic                rst_n;
    logic                opnd_valid;
    logic                opnd_stall;
    mexp_pkg::operands_t opnd;
    logic                res_valid;
    logic                res_stall;
    mexp_pkg::answer_t   res;
    int                  fail_count;
    int                  pending_answers;

    modular_exponentiation #(
        .WIDTH(DUT_WIDTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .opnd_valid(opnd_valid),
        .opnd_stall(opnd_stall),
        .opnd(opnd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res)
    );

    // The checker watches both channels, predicts each answer and compares.
    modexp_checker #(
        .WIDTH(DUT_WIDTH)
    ) answer_check (
        .clk(clk),
        .rst_n(rst_n),
        .opnd_valid(opnd_valid),
        .opnd_stall(opnd_stall),
        .opnd(opnd),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res(res),
        .fail_count(fail_count),
        .pending_answers(pending_answers)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one operand beat and returns in the time step of its acceptance. Valid stays
    // high afterward, so a following call simply replaces the payload. Unless the caller
    // asks for a steady stream, valid drops for a random gap first, with odds of 8 in 100.
    task automatic offer_operands(input mexp_pkg::operands_t x, input bit steady);
        while (!steady && $urandom_range(99) < 8)
        begin
            opnd_valid <= 1'b0;
            @(posedge clk);
        end
        opnd <= x;
        opnd_valid <= 1'b1;
        do
            @(posedge clk);
        while (opnd_stall);
    endtask

    // Lowers valid and waits until every predicted answer has come back. The checker's
    // count is registered, so the task waits for a clock edge before it first trusts it.
    task automatic drain_answers();
        opnd_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_answers != 0);
    endtask

    // Random operands. Most exponents are short, since every exponent bit costs one or two
    // full multiplications in the block; about one item in eight gets a full 64-bit
    // exponent so that every exponent bit is exercised. Moduli mix zero, one, small values,
    // 32-bit values and full-width values.
    function automatic mexp_pkg::operands_t random_operands();
        mexp_pkg::operands_t x;
        int unsigned pick;
        int unsigned len;
        logic [63:0] r;
        x.base_value = {$urandom, $urandom};
        if ($urandom_range(99) < 15)
            x.base_value = 64'($urandom_range(0, 15));
        pick = $urandom_range(99);
        if (pick < 4)
            x.modulus_value = '0;
        else if (pick < 8)
            x.modulus_value = 64'd1;
        else if (pick < 30)
            x.modulus_value = 64'($urandom_range(2, 255));
        else if (pick < 55)
            x.modulus_value = {32'd0, $urandom};
        else
            x.modulus_value = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            x.exponent_value = '0;
        end
        else if (pick < 87)
        begin
            len = $urandom_range(1, 12);
            r = {$urandom, $urandom};
            x.exponent_value = (r & ((64'd1 << len) - 64'd1)) | (64'd1 << (len - 1));
        end
        else
        begin
            x.exponent_value = {$urandom, $urandom};
        end
        return x;
    endfunction

    // Receiver. It stalls at random with odds of 8 in 100, never between its 45th and
    // 75th result, and once, after its 25th result, holds the channel off for longer
    // than the slowest item takes. During that hold the sender keeps offering, so
    // the block finishes the next item, holds its answer and stalls its input.
    initial
    begin
        int results_seen;
        int hold_left;
        bit hold_done;
        results_seen = 0;
        hold_left = 0;
        hold_done = 1'b0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                results_seen++;
            if (results_seen == 25 && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = 20000;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else if (results_seen >= 45 && results_seen < 75)
            begin
                res_stall <= 1'b0;
            end
            else
            begin
                res_stall <= ($urandom_range(99) < 8);
            end
        end
    end

    // Sender and verdict.
    initial
    begin
        int unsigned k;
        rst_n <= 1'b0;
        opnd_valid <= 1'b0;
        opnd <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A zero modulus reports an error whatever the exponent, a zero exponent included.
        offer_operands(mexp_pkg::operands_t'{64'd5, 64'd0, 64'd0}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd7, 64'd13, 64'd0}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{ALL_ONES, ALL_ONES, 64'd0}, 1'b0);
        // A zero exponent answers 1 unreduced, even for a modulus of one.
        offer_operands(mexp_pkg::operands_t'{64'd9, 64'd0, 64'd1}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{ALL_ONES, 64'd0, ALL_ONES}, 1'b0);
        // A nonzero exponent with a modulus of one gives zero.
        offer_operands(mexp_pkg::operands_t'{64'd123, 64'd77, 64'd1}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd0, 64'd5, 64'd7}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd4, 64'd13, 64'd497}, 1'b0);
        // Bases above the modulus must be reduced first.
        offer_operands(mexp_pkg::operands_t'{64'd1000, 64'd1, 64'd7}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd1000, 64'd3, 64'd7}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd17, 64'd17, 64'd17}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{TOP_BIT, 64'd2, 64'd2}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd2, 64'd64, ALL_ONES}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{ALL_ONES, 64'd2, 64'h1_0000_0001}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd12345, 64'd255, TOP_BIT}, 1'b0);
        // Full-width extremes, with the long exponents the block is slowest on.
        offer_operands(mexp_pkg::operands_t'{ALL_ONES, ALL_ONES, ALL_ONES}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{ALL_ONES - 64'd1, ALL_ONES, BIG_PRIME}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd3, TOP_BIT, BIG_PRIME}, 1'b0);
        offer_operands(mexp_pkg::operands_t'{64'd1, ALL_ONES, 64'd3}, 1'b0);

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // Once in the run the sender pauses until the block has answered everything.
            if (k == 70)
                drain_answers();
            offer_operands(random_operands(), k >= 40 && k < 65);
        end

        drain_answers();
        // Any stray beat after the last answer would show up within this window.
        repeat (2 * DUT_WIDTH + 16) @(posedge clk);
        if (fail_count == 0)
            $display("modular_exponentiation_tb OK");
        else
            $display("modular_exponentiation_tb NOT OK");
        $finish;
    end

    // Safety net: well beyond the slowest correct run, every item at full exponent length.
    initial
    begin
        #50_000_000;
        $display("modular_exponentiation_tb NOT OK");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/mexp_pkg.sv
rtl/core/mexp_dp.sv
rtl/core/mexp_ctrl.sv
rtl/core/modular_exponentiation.sv
tb/modexp_checker.sv
tb/modular_exponentiation_tb.sv
